>>> rtl/core/tbpm_pkg.sv
// ----------------------------------------------------------------------------
// tbpm_pkg: shared types, constants and step functions of the point mapper
// Register indexes, reset values and the iteration steps of the dividers and
// square-root units.
// ----------------------------------------------------------------------------
package tbpm_pkg;

   // Configuration port
   localparam int CFG_W      = 12;
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] REG_VIEW_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_VIEW_HEIGHT = 1'b1;
   localparam logic [CFG_W-1:0] VIEW_WIDTH_RST  = 12'd640;
   localparam logic [CFG_W-1:0] VIEW_HEIGHT_RST = 12'd480;

   // Q.32 constants: 1.0 and round(1.001 * 2^32)
   localparam logic [32:0] RAD_ONE  = 33'h1_0000_0000;
   localparam logic [32:0] RAD_BIAS = 33'd4299262263;

   // Square-root units: steps per unit
   localparam int SQ1_STEPS = 17;
   localparam int SQ2_STEPS = 32;

   // Square root of a 34-bit value, two radicand bits a step
   typedef struct packed {
      logic [33:0] val;
      logic [17:0] rem;
      logic [16:0] root;
   } sq1_state_type;

   // Square root of a 64-bit value, two radicand bits a step
   typedef struct packed {
      logic [63:0] val;
      logic [32:0] rem;
      logic [31:0] root;
   } sq2_state_type;

   // One restoring step against a 12-bit divisor: returns {remainder, bit}
   function automatic logic [CFG_W:0] div1_step(input logic [CFG_W-1:0] rem,
                                                input logic nbit,
                                                input logic [CFG_W-1:0] den);
      logic [CFG_W:0] t;
      logic [CFG_W:0] r;
      logic ge;
      t  = {rem, nbit};
      ge = (t >= {1'b0, den});
      r  = ge ? (t - {1'b0, den}) : t;
      return {r[CFG_W-1:0], ge};
   endfunction

   // One restoring step against a 32-bit divisor: returns {remainder, bit}
   function automatic logic [32:0] div2_step(input logic [31:0] rem,
                                             input logic [31:0] den);
      logic [32:0] t;
      logic [32:0] r;
      logic ge;
      t  = {rem, 1'b0};
      ge = (t >= {1'b0, den});
      r  = ge ? (t - {1'b0, den}) : t;
      return {r[31:0], ge};
   endfunction

   function automatic sq1_state_type sq1_step(input sq1_state_type s);
      logic [19:0] t;
      logic [19:0] trial;
      logic [19:0] r;
      logic ge;
      sq1_state_type n;
      t      = {s.rem, s.val[33:32]};
      trial  = {1'b0, s.root, 2'b01};
      ge     = (t >= trial);
      r      = ge ? (t - trial) : t;
      n.rem  = r[17:0];
      n.root = {s.root[15:0], ge};
      n.val  = {s.val[31:0], 2'b00};
      return n;
   endfunction

   function automatic sq2_state_type sq2_step(input sq2_state_type s);
      logic [34:0] t;
      logic [34:0] trial;
      logic [34:0] r;
      logic ge;
      sq2_state_type n;
      t      = {s.rem, s.val[63:62]};
      trial  = {1'b0, s.root, 2'b01};
      ge     = (t >= trial);
      r      = ge ? (t - trial) : t;
      n.rem  = r[32:0];
      n.root = {s.root[30:0], ge};
      n.val  = {s.val[61:0], 2'b00};
      return n;
   endfunction

endpackage

>>> rtl/core/trackball_point_mapper_core.sv
// ----------------------------------------------------------------------------
// trackball_point_mapper_core: cursor position to unit vector on a trackball
// Pipelined through the bit-per-stage dividers and square-root units; one
// transaction per cycle while the output transaction is not held.
// Synchronous reset empties the pipeline and restores a 640 x 480 window.
// ----------------------------------------------------------------------------
module trackball_point_mapper_core #(
   parameter int COORD_BITS    = 14,
   parameter int OUT_FRAC_BITS = 15
) (
   input  logic clock,
   input  logic reset,
   // tdata: cursor_x, cursor_y
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]          req_tdata,
   // tdata: unit_x, unit_y, unit_z
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [((3*OUT_FRAC_BITS+2+7)/8)*8-1:0]     rsp_tdata,
   input  logic                                       csr_we,
   input  logic [tbpm_pkg::CSR_ADDR_W-1:0]            csr_addr,
   input  logic [tbpm_pkg::CFG_W-1:0]                 csr_wdata
);

   localparam int CW     = tbpm_pkg::CFG_W;
   localparam int F      = OUT_FRAC_BITS;
   localparam int MAGW   = (COORD_BITS >= 12) ? COORD_BITS + 1 : 13;
   localparam int NUMW   = MAGW + 1;
   localparam int QB     = MAGW + 16;
   localparam int SATW   = (QB > 33) ? QB : 33;
   localparam int SQ1    = tbpm_pkg::SQ1_STEPS;
   localparam int SQ2    = tbpm_pkg::SQ2_STEPS;
   localparam int CLAST  = 5 + SQ1 + SQ2;
   localparam int LAT    = 5 + QB + CLAST + F;
   localparam int OUT_W  = ((3*F+2+7)/8)*8;
   localparam logic [SATW-1:0] SAT_NEG = SATW'(64'h8000_0000);
   localparam logic [SATW-1:0] SAT_POS = SATW'(64'h7FFF_FFFF);

   // Configuration registers
   logic [CW-1:0] view_width_ff;
   logic [CW-1:0] view_height_ff;
   logic [CW-1:0] den [0:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         view_width_ff  <= tbpm_pkg::VIEW_WIDTH_RST;
         view_height_ff <= tbpm_pkg::VIEW_HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            tbpm_pkg::REG_VIEW_WIDTH:  view_width_ff  <= csr_wdata;
            tbpm_pkg::REG_VIEW_HEIGHT: view_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Use a zero size as one
   assign den[0] = (view_width_ff == '0) ? CW'(1) : view_width_ff;
   assign den[1] = (view_height_ff == '0) ? CW'(1) : view_height_ff;

   // Pipeline control: advance unless the output transaction is held
   logic           pipe_en;
   logic [LAT-1:0] vld_ff;

   assign pipe_en    = ~vld_ff[LAT-1] | rsp_tready;
   assign req_tready = pipe_en;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // Input stage
   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         x_ff <= req_tdata[COORD_BITS-1:0];
         y_ff <= req_tdata[2*COORD_BITS-1:COORD_BITS];
      end
   end

   // Centre: 2x - w and h - 2y, split into sign and magnitude
   logic [NUMW-1:0] num_in [0:1];
   logic [NUMW-1:0] abs_in [0:1];

   assign num_in[0] = {{(NUMW-COORD_BITS-1){x_ff[COORD_BITS-1]}}, x_ff, 1'b0}
                      - NUMW'(den[0]);
   assign num_in[1] = NUMW'(den[1])
                      - {{(NUMW-COORD_BITS-1){y_ff[COORD_BITS-1]}}, y_ff, 1'b0};

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         abs_in[l] = num_in[l][NUMW-1] ? (~num_in[l] + NUMW'(1)) : num_in[l];
      end
   end

   // Normalizing divider: one quotient bit a stage
   logic [CW-1:0] d1_rem_ff  [0:1][0:QB];
   logic [QB-1:0] d1_bits_ff [0:1][0:QB];
   logic [QB:0]   d1_neg_ff  [0:1];
   logic [CW:0]   d1_res     [0:1][1:QB];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         for (int k = 1; k <= QB; k++) begin
            d1_res[l][k] = tbpm_pkg::div1_step(d1_rem_ff[l][k-1],
                                               d1_bits_ff[l][k-1][QB-1], den[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int l = 0; l < 2; l++) begin
            d1_rem_ff[l][0]  <= '0;
            d1_bits_ff[l][0] <= {abs_in[l][MAGW-1:0], 16'h0000};
            d1_neg_ff[l][0]  <= num_in[l][NUMW-1];
            for (int k = 1; k <= QB; k++) begin
               d1_rem_ff[l][k]  <= d1_res[l][k][CW:1];
               d1_bits_ff[l][k] <= {d1_bits_ff[l][k-1][QB-2:0], d1_res[l][k][0]};
               d1_neg_ff[l][k]  <= d1_neg_ff[l][k-1];
            end
         end
      end
   end

   // Saturate to Q16.16 and carry magnitude and sign to the final dividers
   logic [SATW-1:0] q1_ext [0:1];
   logic [SATW-1:0] q1_lim [0:1];
   logic [31:0]     ca_ff  [0:1][0:CLAST];
   logic [CLAST:0]  cn_ff  [0:1];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         q1_ext[l] = SATW'(d1_bits_ff[l][QB]);
         q1_lim[l] = d1_neg_ff[l][QB] ? SAT_NEG : SAT_POS;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int l = 0; l < 2; l++) begin
            ca_ff[l][0] <= (q1_ext[l] > q1_lim[l]) ? q1_lim[l][31:0] : q1_ext[l][31:0];
            cn_ff[l][0] <= d1_neg_ff[l][QB];
            for (int k = 1; k <= CLAST; k++) begin
               ca_ff[l][k] <= ca_ff[l][k-1];
               cn_ff[l][k] <= cn_ff[l][k-1];
            end
         end
      end
   end

   // Squares, planar sum, and clamped radicand for nz
   logic [63:0] sq_ff [0:1];
   logic [63:0] sxy_ff;
   logic [32:0] clamp_in;

   assign clamp_in = (sxy_ff[63:32] != '0) ? tbpm_pkg::RAD_ONE : {1'b0, sxy_ff[31:0]};

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int l = 0; l < 2; l++) begin
            sq_ff[l] <= 64'(ca_ff[l][0]) * 64'(ca_ff[l][0]);
         end
         sxy_ff <= sq_ff[0] + sq_ff[1];
      end
   end

   // nz = isqrt(1.001 - d^2), two radicand bits a stage
   tbpm_pkg::sq1_state_type sq1_ff  [0:SQ1];
   logic [63:0]             sxy1_ff [0:SQ1];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sq1_ff[0].val  <= {1'b0, tbpm_pkg::RAD_BIAS - clamp_in};
         sq1_ff[0].rem  <= '0;
         sq1_ff[0].root <= '0;
         sxy1_ff[0]     <= sxy_ff;
         for (int k = 1; k <= SQ1; k++) begin
            sq1_ff[k]  <= tbpm_pkg::sq1_step(sq1_ff[k-1]);
            sxy1_ff[k] <= sxy1_ff[k-1];
         end
      end
   end

   // Square nz and form the length radicand
   logic [33:0] nzsq_ff;
   logic [16:0] nz_ff;
   logic [63:0] sxy2_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         nzsq_ff <= 34'(sq1_ff[SQ1].root) * 34'(sq1_ff[SQ1].root);
         nz_ff   <= sq1_ff[SQ1].root;
         sxy2_ff <= sxy1_ff[SQ1];
      end
   end

   // Length = isqrt(nx^2 + ny^2 + nz^2)
   tbpm_pkg::sq2_state_type sq2_ff [0:SQ2];
   logic [16:0]             nz2_ff [0:SQ2];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sq2_ff[0].val  <= sxy2_ff + 64'(nzsq_ff);
         sq2_ff[0].rem  <= '0;
         sq2_ff[0].root <= '0;
         nz2_ff[0]      <= nz_ff;
         for (int k = 1; k <= SQ2; k++) begin
            sq2_ff[k]  <= tbpm_pkg::sq2_step(sq2_ff[k-1]);
            nz2_ff[k]  <= nz2_ff[k-1];
         end
      end
   end

   // Scale by the length: three lanes, one quotient bit a stage
   logic [31:0] od_c_in   [0:2];
   logic [31:0] od_len_in;
   logic [31:0] od_rem_ff [0:2][0:F];
   logic [F:0]  od_q_ff   [0:2][0:F];
   logic [31:0] od_len_ff [0:F];
   logic [F:0]  od_neg_ff [0:1];
   logic [32:0] od_res    [0:2][1:F];

   assign od_c_in[0] = ca_ff[0][CLAST];
   assign od_c_in[1] = ca_ff[1][CLAST];
   assign od_c_in[2] = 32'(nz2_ff[SQ2]);
   assign od_len_in  = sq2_ff[SQ2].root;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         for (int k = 1; k <= F; k++) begin
            od_res[l][k] = tbpm_pkg::div2_step(od_rem_ff[l][k-1], od_len_ff[k-1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         od_len_ff[0] <= od_len_in;
         for (int l = 0; l < 2; l++) begin
            od_neg_ff[l][0] <= cn_ff[l][CLAST];
            for (int k = 1; k <= F; k++) begin
               od_neg_ff[l][k] <= od_neg_ff[l][k-1];
            end
         end
         for (int l = 0; l < 3; l++) begin
            od_q_ff[l][0]   <= (F+1)'(od_c_in[l] >= od_len_in);
            od_rem_ff[l][0] <= (od_c_in[l] >= od_len_in) ? (od_c_in[l] - od_len_in)
                                                         : od_c_in[l];
            for (int k = 1; k <= F; k++) begin
               od_rem_ff[l][k] <= od_res[l][k][32:1];
               od_q_ff[l][k]   <= {od_q_ff[l][k-1][F-1:0], od_res[l][k][0]};
            end
         end
         for (int k = 1; k <= F; k++) begin
            od_len_ff[k] <= od_len_ff[k-1];
         end
      end
   end

   // Output stage: saturate +1, apply sign
   logic [F-1:0] mag_in [0:2];
   logic [F:0]   unit_x_ff;
   logic [F:0]   unit_y_ff;
   logic [F-1:0] unit_z_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         mag_in[l] = od_q_ff[l][F][F] ? {F{1'b1}} : od_q_ff[l][F][F-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         unit_x_ff <= od_neg_ff[0][F] ? (~od_q_ff[0][F] + (F+1)'(1)) : {1'b0, mag_in[0]};
         unit_y_ff <= od_neg_ff[1][F] ? (~od_q_ff[1][F] + (F+1)'(1)) : {1'b0, mag_in[1]};
         unit_z_ff <= mag_in[2];
      end
   end

   assign rsp_tdata = OUT_W'({unit_z_ff, unit_y_ff, unit_x_ff});

endmodule

>>> sim/trackball_point_mapper_core_tb.sv
// ----------------------------------------------------------------------------
// trackball_point_mapper_core_tb: self-checking bench for the trackball mapper
// Drives cursor positions in random bursts under several window sizes.
// Each accepted position is mapped by an in-bench fixed-point mapper.
// Every result transaction is compared field by field, in order, with the
// oldest expected unit vector.
// ----------------------------------------------------------------------------
module trackball_point_mapper_core_tb;

   localparam int CB        = 14;
   localparam int OFB       = 15;
   localparam int CW        = tbpm_pkg::CFG_W;
   localparam int AW        = tbpm_pkg::CSR_ADDR_W;
   localparam int REQ_W     = ((2*CB+7)/8)*8;
   localparam int RSP_W     = ((3*OFB+2+7)/8)*8;
   localparam int DRAIN_CYC = 200;

   typedef struct packed {
      logic signed [15:0] ux;
      logic signed [15:0] uy;
      logic [14:0]        uz;
   } unit_vec_type;

   // Expected unit vectors and the window they are mapped against
   class unit_vec_board_type;
      unit_vec_type vec_q[$];
      int           view_w = tbpm_pkg::VIEW_WIDTH_RST;
      int           view_h = tbpm_pkg::VIEW_HEIGHT_RST;
      int           errors = 0;

      function void report(string what, longint got, longint want);
         $display("MISMATCH %s: got %0d expected %0d", what, got, want);
         errors++;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res;
         longint unsigned bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v   = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      function longint norm_q16(longint num, longint den);
         longint q;
         q = (num * 65536) / den;
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         if (q < -64'sd2147483648) q = -64'sd2147483648;
         return q;
      endfunction

      function longint scale_unit(longint c, longint len);
         longint one;
         longint q;
         one = 64'sd1 << OFB;
         q   = (c * one) / len;
         if (q > one - 1) q = one - 1;
         if (q < -one) q = -one;
         return q;
      endfunction

      // Map one accepted cursor position and queue the unit vector
      function void note_cursor(logic signed [CB-1:0] cx, logic signed [CB-1:0] cy);
         longint w, h, x, y, nx, ny, len;
         longint unsigned ax, ay, sxy, d2, nz;
         unit_vec_type v;
         x   = cx;
         y   = cy;
         w   = (view_w == 0) ? 1 : view_w;
         h   = (view_h == 0) ? 1 : view_h;
         nx  = norm_q16(2*x - w, w);
         ny  = norm_q16(h - 2*y, h);
         ax  = (nx < 0) ? -nx : nx;
         ay  = (ny < 0) ? -ny : ny;
         sxy = ax*ax + ay*ay;
         d2  = (sxy < 64'h1_0000_0000) ? sxy : 64'h1_0000_0000;
         nz  = int_sqrt(64'd4299262263 - d2);
         len = int_sqrt(sxy + nz*nz);
         v.ux = 16'(scale_unit(nx, len));
         v.uy = 16'(scale_unit(ny, len));
         v.uz = 15'(scale_unit(nz, len));
         vec_q.insert(vec_q.size(), v);
      endfunction

      // Compare one result transaction with the oldest expectation
      function void check_vec(logic [RSP_W-1:0] d);
         unit_vec_type w;
         if (vec_q.size() == 0) begin
            report("unexpected result", d[46:0], 0);
            return;
         end
         w = vec_q.pop_front();
         if (d[15:0] !== w.ux)  report("unit_x", $signed(d[15:0]), w.ux);
         if (d[31:16] !== w.uy) report("unit_y", $signed(d[31:16]), w.uy);
         if (d[46:32] !== w.uz) report("unit_z", d[46:32], w.uz);
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_we = 1'b0;
   logic [AW-1:0]    csr_addr = tbpm_pkg::REG_VIEW_WIDTH;
   logic [CW-1:0]    csr_wdata = '0;

   unit_vec_board_type board = new();
   int  burst_left = 1;
   bit  hold_toggle = 1'b0;

   trackball_point_mapper_core #(.COORD_BITS(CB), .OUT_FRAC_BITS(OFB)) dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Log accepted transactions on both sides
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_cursor(req_tdata[CB-1:0], req_tdata[2*CB-1:CB]);
         if (rsp_tvalid && rsp_tready)
            board.check_vec(rsp_tdata);
      end
   end

   // Receiver: random stall stretches, plus a long hold-off on request
   initial begin
      int  seg_left;
      int  stall_pct;
      int  hold_left;
      bit  seen_toggle;
      seg_left    = 0;
      stall_pct   = 0;
      hold_left   = 0;
      seen_toggle = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_toggle != seen_toggle) begin
            seen_toggle = hold_toggle;
            hold_left   = 400;
         end
         if (seg_left == 0) begin
            seg_left  = $urandom_range(5, 60);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 70);
         end
         seg_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Write one register, then idle so writes never overlap
   task automatic write_reg(logic [AW-1:0] addr, int val);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= CW'(val);
      @(posedge clock);
      csr_we    <= 1'b0;
      if (addr == tbpm_pkg::REG_VIEW_WIDTH) board.view_w = val;
      else board.view_h = val;
      @(posedge clock);
   endtask

   // Offer one position, hold until accepted, then maybe gap
   task automatic send_cursor(int x, int y);
      int gap;
      req_tdata  <= {{(REQ_W-2*CB){1'b0}}, y[CB-1:0], x[CB-1:0]};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.vec_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic random_cursor();
      int x, y;
      if ($urandom_range(0, 3) == 0) begin
         x = $urandom_range(0, 16383) - 8192;
         y = $urandom_range(0, 16383) - 8192;
      end else begin
         x = $urandom_range(0, board.view_w + 1);
         y = $urandom_range(0, board.view_h + 1);
      end
      send_cursor(x, y);
   endtask

   task automatic edge_cursors();
      int w, h;
      w = board.view_w;
      h = board.view_h;
      send_cursor(0, 0);
      send_cursor(w, h);
      send_cursor(w / 2, h / 2);
      send_cursor(-8192, -8192);
      send_cursor(8191, 8191);
   endtask

   initial begin
      int ws[8] = '{1, 4095, 0, 4095, -1, -1, -1, 640};
      int hs[8] = '{1, 4095, 4095, 0, -1, -1, -1, 480};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed positions under the reset window
      send_cursor(320, 240);
      send_cursor(0, 0);
      send_cursor(640, 480);
      send_cursor(0, 480);
      send_cursor(640, 0);
      send_cursor(-8192, -8192);
      send_cursor(8191, 8191);
      send_cursor(-8192, 8191);
      send_cursor(8191, -8192);
      send_cursor(320, 0);
      send_cursor(0, 240);
      send_cursor(320, 5000);
      send_cursor(319, 241);
      send_cursor(-1, -1);
      send_cursor(6000, 240);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         write_reg(tbpm_pkg::REG_VIEW_WIDTH,
                   (ws[p] < 0) ? $urandom_range(1, 4095) : ws[p]);
         write_reg(tbpm_pkg::REG_VIEW_HEIGHT,
                   (hs[p] < 0) ? $urandom_range(1, 4095) : hs[p]);
         edge_cursors();
         for (int i = 0; i < 175; i++) begin
            // Hold off the receiver while positions keep coming
            if (p == 4 && i == 20) hold_toggle = ~hold_toggle;
            // Pause the sender until the pipeline has emptied
            if (p == 5 && i == 80) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (board.vec_q.size() != 0) @(posedge clock);
            end
            random_cursor();
         end
         wait_drained();
      end

      if (board.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(8 * 400000);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/tbpm_pkg.sv
rtl/core/trackball_point_mapper_core.sv
sim/trackball_point_mapper_core_tb.sv
